// ===== rtl/core/hmmap_pkg.sv =====
// Shared types and constants for the handheld memory map / MBC1 unit.
package hmmap_pkg;

    // Region codes reported with every decoded access
    typedef enum logic [3:0] {
        REGION_BOOT_ROM  = 4'd0,
        REGION_CART_ROM  = 4'd1,
        REGION_VRAM      = 4'd2,
        REGION_CART_RAM  = 4'd3,
        REGION_WORK_RAM  = 4'd4,
        REGION_OAM       = 4'd5,
        REGION_HIGH_RAM  = 4'd6,
        REGION_JOYPAD    = 4'd7,
        REGION_VIDEO_REG = 4'd8,
        REGION_INT_REG   = 4'd9,
        REGION_NONE      = 4'd10
    } t_region;

    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned TARGET_W   = 21;
    localparam int unsigned DATA_W     = 8;
    localparam int unsigned BANK_MAX_W = 7;

    localparam logic [0:0] CMD_READ  = 1'b0;
    localparam logic [0:0] CMD_WRITE = 1'b1;

    localparam logic [DATA_W-1:0] CART_MBC1 = 8'h01;

    // Memory map boundaries
    localparam logic [ADDR_W-1:0] ADDR_ROM_BANKED = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_VRAM       = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_CART_RAM   = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_WORK_RAM   = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_OAM        = 16'hFE00;
    localparam logic [ADDR_W-1:0] ADDR_UNMAPPED   = 16'hFEA0;
    localparam logic [ADDR_W-1:0] ADDR_IO         = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_IF         = 16'hFF0F;
    localparam logic [ADDR_W-1:0] ADDR_VIDEO      = 16'hFF40;
    localparam logic [ADDR_W-1:0] ADDR_IO_END     = 16'hFF7F;
    localparam logic [ADDR_W-1:0] ADDR_IE         = 16'hFFFF;
    localparam logic [ADDR_W-1:0] ADDR_BOOT_END   = 16'h0100;
    localparam logic [ADDR_W-1:0] ADDR_ENTRY_END  = 16'h1000;

    // MBC1 control window, selected by address bits 14:13
    localparam logic [1:0] MBC_RAM_EN   = 2'd0;
    localparam logic [1:0] MBC_ROM_LOW  = 2'd1;
    localparam logic [1:0] MBC_ROM_HIGH = 2'd2;
    localparam logic [1:0] MBC_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;

    // Bank controller state seen by the decoder
    typedef struct packed {
        logic                  boot_overlay;
        logic [BANK_MAX_W-1:0] rom_window_bank;
        logic [1:0]            ram_bank;
        logic [DATA_W-1:0]     int_enable;
        logic [DATA_W-1:0]     int_flags;
    } t_bank_state;

    // Decoder result plus the state updates it asks for
    typedef struct packed {
        t_region               region;
        logic [TARGET_W-1:0]   target;
        logic                  strobe;
        logic [DATA_W-1:0]     read_value;
        logic                  mbc_wr;
        logic                  ie_wr;
        logic                  if_wr;
        logic                  boot_clear;
    } t_decode;

endpackage

// ===== rtl/core/hmmap_decode.sv =====
// Address decoder: region select, address translation and internal register reads.
module hmmap_decode #(
    parameter int unsigned RAM_BANKS = 4
) (
    input  logic                              i_cmd,
    input  logic [hmmap_pkg::ADDR_W-1:0]      i_addr,
    input  logic                              i_pc_at_entry,
    input  hmmap_pkg::t_bank_state            i_state,
    output hmmap_pkg::t_decode                o_dec
);

    localparam logic [2:0] RAM_BANKS_C = 3'(RAM_BANKS);

    logic       wr;
    logic [2:0] ram_bank_mod;

    assign wr = (i_cmd == hmmap_pkg::CMD_WRITE);

    // ram_bank modulo bank count; at most three subtractions on a 2-bit value
    always_comb begin
        ram_bank_mod = {1'b0, i_state.ram_bank};
        for (int i = 0; i < 3; i++) begin
            if (ram_bank_mod >= RAM_BANKS_C) begin
                ram_bank_mod = ram_bank_mod - RAM_BANKS_C;
            end
        end
    end

    always_comb begin
        o_dec            = '0;
        o_dec.region     = hmmap_pkg::REGION_NONE;

        if (i_addr < hmmap_pkg::ADDR_VRAM) begin
            o_dec.region = hmmap_pkg::REGION_CART_ROM;
            if (wr) begin
                o_dec.target = 21'(i_addr);
                o_dec.mbc_wr = 1'b1;
            end else if (i_addr < hmmap_pkg::ADDR_ROM_BANKED) begin
                o_dec.target = 21'(i_addr);
                if (i_state.boot_overlay && (i_addr < hmmap_pkg::ADDR_BOOT_END)) begin
                    o_dec.region = hmmap_pkg::REGION_BOOT_ROM;
                end else begin
                    o_dec.boot_clear = i_state.boot_overlay && i_pc_at_entry &&
                                       (i_addr < hmmap_pkg::ADDR_ENTRY_END);
                end
            end else begin
                o_dec.target = {i_state.rom_window_bank, i_addr[13:0]};
            end
        end else if (i_addr < hmmap_pkg::ADDR_CART_RAM) begin
            o_dec.region = hmmap_pkg::REGION_VRAM;
            o_dec.target = 21'(i_addr[12:0]);
            o_dec.strobe = wr;
        end else if (i_addr < hmmap_pkg::ADDR_WORK_RAM) begin
            o_dec.region = hmmap_pkg::REGION_CART_RAM;
            o_dec.target = 21'({ram_bank_mod[1:0], i_addr[12:0]});
            o_dec.strobe = wr;
        end else if (i_addr < hmmap_pkg::ADDR_OAM) begin
            // includes the echo area
            o_dec.region = hmmap_pkg::REGION_WORK_RAM;
            o_dec.target = 21'(i_addr[12:0]);
            o_dec.strobe = wr;
        end else if (i_addr < hmmap_pkg::ADDR_UNMAPPED) begin
            o_dec.region = hmmap_pkg::REGION_OAM;
            o_dec.target = 21'(i_addr[7:0]);
            o_dec.strobe = wr;
        end else if (i_addr < hmmap_pkg::ADDR_IO) begin
            o_dec.region = hmmap_pkg::REGION_NONE;
        end else if (i_addr == hmmap_pkg::ADDR_IE) begin
            o_dec.region     = hmmap_pkg::REGION_INT_REG;
            o_dec.target     = 21'(i_addr[7:0]);
            o_dec.ie_wr      = wr;
            o_dec.read_value = wr ? '0 : i_state.int_enable;
        end else if (i_addr > hmmap_pkg::ADDR_IO_END) begin
            o_dec.region = hmmap_pkg::REGION_HIGH_RAM;
            o_dec.target = 21'(i_addr[6:0]);
            o_dec.strobe = wr;
        end else if (i_addr == hmmap_pkg::ADDR_IO) begin
            o_dec.region = hmmap_pkg::REGION_JOYPAD;
            o_dec.strobe = wr;
        end else if (i_addr == hmmap_pkg::ADDR_IF) begin
            o_dec.region     = hmmap_pkg::REGION_INT_REG;
            o_dec.target     = 21'(i_addr[7:0]);
            o_dec.if_wr      = wr;
            o_dec.read_value = wr ? '0 : i_state.int_flags;
        end else if (i_addr >= hmmap_pkg::ADDR_VIDEO) begin
            o_dec.region = hmmap_pkg::REGION_VIDEO_REG;
            o_dec.target = 21'(i_addr[5:0]);
            o_dec.strobe = wr;
        end
    end

endmodule

// ===== rtl/core/hmmap_bank_regs.sv =====
// MBC1 bank registers, boot overlay flag, IE/IF and the cartridge type register.
module hmmap_bank_regs #(
    parameter int unsigned ROM_BANK_BITS = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [hmmap_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                            i_fire,
    input  hmmap_pkg::t_decode              i_dec,
    input  logic [1:0]                      i_mbc_sel,
    input  logic [hmmap_pkg::DATA_W-1:0]    i_wr_data,
    output hmmap_pkg::t_bank_state          o_state,
    output logic                            o_ram_enable_next
);

    localparam int unsigned BW = hmmap_pkg::BANK_MAX_W;

    logic [hmmap_pkg::DATA_W-1:0] r_cart_type;
    logic                         r_boot_overlay, n_boot_overlay;
    logic [ROM_BANK_BITS-1:0]     r_rom_bank, n_rom_bank;
    logic [ROM_BANK_BITS-1:0]     r_rom_window_bank, n_rom_window_bank;
    logic [1:0]                   r_ram_bank, n_ram_bank;
    logic                         r_ram_enable, n_ram_enable;
    logic                         r_bank_mode, n_bank_mode;
    logic [hmmap_pkg::DATA_W-1:0] r_int_enable, n_int_enable;
    logic [hmmap_pkg::DATA_W-1:0] r_int_flags, n_int_flags;

    logic          mbc_en;
    logic [BW-1:0] rom_bank_full;
    logic [BW-1:0] bank_new;
    logic [4:0]    low_bits;

    assign mbc_en        = i_fire && i_dec.mbc_wr && (r_cart_type == hmmap_pkg::CART_MBC1);
    assign rom_bank_full = BW'(r_rom_bank);
    assign low_bits      = (i_wr_data[4:0] == 5'd0) ? 5'd1 : i_wr_data[4:0];

    always_comb begin
        n_boot_overlay    = r_boot_overlay;
        n_rom_bank        = r_rom_bank;
        n_rom_window_bank = r_rom_window_bank;
        n_ram_bank        = r_ram_bank;
        n_ram_enable      = r_ram_enable;
        n_bank_mode       = r_bank_mode;
        n_int_enable      = r_int_enable;
        n_int_flags       = r_int_flags;
        bank_new          = rom_bank_full;

        if (i_fire && i_dec.boot_clear) begin
            n_boot_overlay = 1'b0;
        end
        if (i_fire && i_dec.ie_wr) begin
            n_int_enable = i_wr_data;
        end
        if (i_fire && i_dec.if_wr) begin
            n_int_flags = i_wr_data;
        end

        if (mbc_en) begin
            case (i_mbc_sel)
                hmmap_pkg::MBC_RAM_EN: begin
                    n_ram_enable = (i_wr_data[3:0] == hmmap_pkg::RAM_EN_KEY);
                end
                hmmap_pkg::MBC_ROM_LOW: begin
                    bank_new          = {rom_bank_full[6:5], low_bits};
                    n_rom_bank        = bank_new[ROM_BANK_BITS-1:0];
                    n_rom_window_bank = bank_new[ROM_BANK_BITS-1:0];
                end
                hmmap_pkg::MBC_ROM_HIGH: begin
                    if (r_bank_mode) begin
                        n_ram_bank = i_wr_data[1:0];
                    end else begin
                        bank_new          = {i_wr_data[1:0], rom_bank_full[4:0]};
                        n_rom_bank        = bank_new[ROM_BANK_BITS-1:0];
                        n_rom_window_bank = bank_new[ROM_BANK_BITS-1:0];
                    end
                end
                hmmap_pkg::MBC_MODE: begin
                    n_bank_mode = i_wr_data[0];
                end
                default: begin
                    n_bank_mode = r_bank_mode;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cart_type       <= '0;
            r_boot_overlay    <= 1'b1;
            r_rom_bank        <= '0;
            r_rom_window_bank <= ROM_BANK_BITS'(1);
            r_ram_bank        <= '0;
            r_ram_enable      <= 1'b0;
            r_bank_mode       <= 1'b0;
            r_int_enable      <= '0;
            r_int_flags       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cart_type <= i_cfg_data;
            end
            r_boot_overlay    <= n_boot_overlay;
            r_rom_bank        <= n_rom_bank;
            r_rom_window_bank <= n_rom_window_bank;
            r_ram_bank        <= n_ram_bank;
            r_ram_enable      <= n_ram_enable;
            r_bank_mode       <= n_bank_mode;
            r_int_enable      <= n_int_enable;
            r_int_flags       <= n_int_flags;
        end
    end

    always_comb begin
        o_state.boot_overlay    = r_boot_overlay;
        o_state.rom_window_bank = BW'(r_rom_window_bank);
        o_state.ram_bank        = r_ram_bank;
        o_state.int_enable      = r_int_enable;
        o_state.int_flags       = r_int_flags;
    end

    assign o_ram_enable_next = n_ram_enable;

endmodule

// ===== rtl/core/handheld_memory_map_with_mbc1_unit.sv =====
// Top level: memory map decoder with MBC1 bank control and IE/IF registers.
// Each accepted bus transaction is captured in an input register, decoded
// against the current bank state and written to the result register when that
// register can take it; bank, boot overlay and IE/IF updates take effect at that
// same edge, so the next transaction already sees them. Throughput is one
// transaction per clock while i_out_stall is low; a transaction passes through
// the input register before the result register takes it. o_in_stall rises
// only while the input register is full and the result register is held by
// i_out_stall. Configuration writes (cartridge type; 1 enables MBC1 control
// writes) are always ready and must be issued only while no transaction is in
// flight. ram_enabled reports the RAM enable flag after the transaction;
// cartridge RAM accesses are not gated by it.
module handheld_memory_map_with_mbc1_unit #(
    parameter int unsigned ROM_BANK_BITS = 7,
    parameter int unsigned RAM_BANKS     = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hmmap_pkg::DATA_W-1:0]    i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [hmmap_pkg::ADDR_W-1:0]    i_bus_addr,
    input  logic [hmmap_pkg::DATA_W-1:0]    i_wr_data,
    input  logic                            i_pc_at_entry,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [3:0]                      o_region,
    output logic [hmmap_pkg::TARGET_W-1:0]  o_target_addr,
    output logic                            o_write_strobe,
    output logic [hmmap_pkg::DATA_W-1:0]    o_read_value,
    output logic                            o_ram_enabled
);

    logic                            r_s1_valid;
    logic                            r_s1_cmd;
    logic [hmmap_pkg::ADDR_W-1:0]    r_s1_addr;
    logic [hmmap_pkg::DATA_W-1:0]    r_s1_data;
    logic                            r_s1_pc;

    logic                            r_out_valid;
    logic [3:0]                      r_region;
    logic [hmmap_pkg::TARGET_W-1:0]  r_target;
    logic                            r_strobe;
    logic [hmmap_pkg::DATA_W-1:0]    r_read_value;
    logic                            r_ram_enabled;

    logic                   s1_adv;
    logic                   s1_take;
    logic                   fire;
    hmmap_pkg::t_decode     dec;
    hmmap_pkg::t_bank_state state;
    logic                   ram_enable_next;

    assign o_cfg_ready = 1'b1;

    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign s1_take    = i_in_valid && !o_in_stall;
    assign fire       = r_s1_valid && s1_adv;

    hmmap_decode #(
        .RAM_BANKS (RAM_BANKS)
    ) u_decode (
        .i_cmd         (r_s1_cmd),
        .i_addr        (r_s1_addr),
        .i_pc_at_entry (r_s1_pc),
        .i_state       (state),
        .o_dec         (dec)
    );

    hmmap_bank_regs #(
        .ROM_BANK_BITS (ROM_BANK_BITS)
    ) u_bank_regs (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_fire            (fire),
        .i_dec             (dec),
        .i_mbc_sel         (r_s1_addr[14:13]),
        .i_wr_data         (r_s1_data),
        .o_state           (state),
        .o_ram_enable_next (ram_enable_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= s1_take || (r_s1_valid && !s1_adv);
            r_out_valid <= fire || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take) begin
            r_s1_cmd  <= i_cmd;
            r_s1_addr <= i_bus_addr;
            r_s1_data <= i_wr_data;
            r_s1_pc   <= i_pc_at_entry;
        end
        if (fire) begin
            r_region      <= dec.region;
            r_target      <= dec.target;
            r_strobe      <= dec.strobe;
            r_read_value  <= dec.read_value;
            r_ram_enabled <= ram_enable_next;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_region       = r_region;
    assign o_target_addr  = r_target;
    assign o_write_strobe = r_strobe;
    assign o_read_value   = r_read_value;
    assign o_ram_enabled  = r_ram_enabled;

endmodule

// ===== rtl/core/hmmap_checker.sv =====
// Port-level checker for the memory map unit, bound to the top level.
module hmmap_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [3:0]                      o_region,
    input logic [hmmap_pkg::TARGET_W-1:0]  o_target_addr,
    input logic                            o_write_strobe,
    input logic [hmmap_pkg::DATA_W-1:0]    o_read_value
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_region) &&
        $stable(o_target_addr) && $stable(o_write_strobe) && $stable(o_read_value))
        else $error("result changed while stalled");

    // unmapped addresses report nothing
    a_none_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_region == 4'(hmmap_pkg::REGION_NONE)) |->
        (o_target_addr == '0) && !o_write_strobe && (o_read_value == '0))
        else $error("unmapped transaction carries data");

    // ROM, boot ROM, IE/IF and unmapped addresses never strobe a write outward
    a_no_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_strobe |->
        (o_region != 4'(hmmap_pkg::REGION_CART_ROM)) &&
        (o_region != 4'(hmmap_pkg::REGION_BOOT_ROM)) &&
        (o_region != 4'(hmmap_pkg::REGION_INT_REG)) &&
        (o_region != 4'(hmmap_pkg::REGION_NONE)))
        else $error("write strobe on a non-writable region");

    // input stall only appears while the output side is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind handheld_memory_map_with_mbc1_unit hmmap_checker u_hmmap_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_region       (o_region),
    .o_target_addr  (o_target_addr),
    .o_write_strobe (o_write_strobe),
    .o_read_value   (o_read_value)
);

// ===== sim/handheld_memory_map_with_mbc1_unit_checker.sv =====
// Checker for the memory map / MBC1 unit: predicts each access and compares results.
module handheld_memory_map_with_mbc1_unit_checker #(
    parameter int unsigned ROM_BANK_BITS = 7,
    parameter int unsigned RAM_BANKS     = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [hmmap_pkg::DATA_W-1:0]   i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_cmd,
    input  logic [hmmap_pkg::ADDR_W-1:0]   i_bus_addr,
    input  logic [hmmap_pkg::DATA_W-1:0]   i_wr_data,
    input  logic                           i_pc_at_entry,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [3:0]                     i_region,
    input  logic [hmmap_pkg::TARGET_W-1:0] i_target_addr,
    input  logic                           i_write_strobe,
    input  logic [hmmap_pkg::DATA_W-1:0]   i_read_value,
    input  logic                           i_ram_enabled,
    output int                             o_fail_cnt,
    output int                             o_pending
);

    localparam int unsigned BMW = hmmap_pkg::BANK_MAX_W;
    localparam int unsigned TW  = hmmap_pkg::TARGET_W;
    localparam int unsigned DW  = hmmap_pkg::DATA_W;
    localparam int unsigned AW  = hmmap_pkg::ADDR_W;

    localparam logic [BMW-1:0] BANK_MASK = BMW'((1 << ROM_BANK_BITS) - 1);

    typedef struct packed {
        hmmap_pkg::t_region  region;
        logic [TW-1:0]       target;
        logic                strobe;
        logic [DW-1:0]       rval;
        logic                ram_en;
    } t_access;

    t_access expected_q[$];
    int      mismatches = 0;
    int      pending    = 0;

    // shadow of the bank controller
    logic [DW-1:0]  cart_type_q;
    logic           boot_on;
    logic [BMW-1:0] rom_bank_q;
    logic [BMW-1:0] window_bank_q;
    logic [1:0]     ram_bank_q;
    logic           ram_en_q;
    logic           bank_mode_q;
    logic [DW-1:0]  ie_q;
    logic [DW-1:0]  if_q;

    assign o_fail_cnt = mismatches;
    assign o_pending  = pending;

    task automatic mbc_control(input logic [AW-1:0] a, input logic [DW-1:0] d);
        logic [4:0] low;
        if (cart_type_q == hmmap_pkg::CART_MBC1) begin
            case (a[14:13])
                hmmap_pkg::MBC_RAM_EN: begin
                    ram_en_q = (d[3:0] == hmmap_pkg::RAM_EN_KEY);
                end
                hmmap_pkg::MBC_ROM_LOW: begin
                    low = d[4:0];
                    if (low == 5'd0) low = 5'd1;
                    rom_bank_q    = ((rom_bank_q & 7'h60) | {2'b00, low}) & BANK_MASK;
                    window_bank_q = rom_bank_q;
                end
                hmmap_pkg::MBC_ROM_HIGH: begin
                    if (bank_mode_q) begin
                        ram_bank_q = d[1:0];
                    end else begin
                        rom_bank_q    = ((rom_bank_q & 7'h1F) | {d[1:0], 5'b00000}) & BANK_MASK;
                        window_bank_q = rom_bank_q;
                    end
                end
                default: begin
                    bank_mode_q = d[0];
                end
            endcase
        end
    endtask

    task automatic predict_access(input logic cmd, input logic [AW-1:0] a,
                                  input logic [DW-1:0] d, input logic pc,
                                  output t_access res);
        res.region = hmmap_pkg::REGION_NONE;
        res.target = '0;
        res.strobe = 1'b0;
        res.rval   = '0;
        if (a < hmmap_pkg::ADDR_VRAM) begin
            if (cmd == hmmap_pkg::CMD_WRITE) begin
                mbc_control(a, d);
                res.region = hmmap_pkg::REGION_CART_ROM;
                res.target = TW'(a);
            end else if (a < hmmap_pkg::ADDR_ROM_BANKED) begin
                if (boot_on && a < hmmap_pkg::ADDR_BOOT_END) begin
                    res.region = hmmap_pkg::REGION_BOOT_ROM;
                end else begin
                    // entry read ends the overlay, and already goes to the cartridge
                    if (boot_on && a < hmmap_pkg::ADDR_ENTRY_END && pc) boot_on = 1'b0;
                    res.region = hmmap_pkg::REGION_CART_ROM;
                end
                res.target = TW'(a);
            end else begin
                res.region = hmmap_pkg::REGION_CART_ROM;
                res.target = TW'(window_bank_q & BANK_MASK) * TW'('h4000)
                           + TW'(a[13:0]);
            end
        end else if (a < hmmap_pkg::ADDR_CART_RAM) begin
            res.region = hmmap_pkg::REGION_VRAM;
            res.target = TW'(a[12:0]);
            res.strobe = cmd;
        end else if (a < hmmap_pkg::ADDR_WORK_RAM) begin
            res.region = hmmap_pkg::REGION_CART_RAM;
            res.target = TW'((int'(ram_bank_q) % RAM_BANKS) * 'h2000)
                       + TW'(a[12:0]);
            res.strobe = cmd;
        end else if (a < hmmap_pkg::ADDR_OAM) begin
            // echo area folds onto work RAM
            res.region = hmmap_pkg::REGION_WORK_RAM;
            res.target = TW'(a[12:0]);
            res.strobe = cmd;
        end else if (a < hmmap_pkg::ADDR_UNMAPPED) begin
            res.region = hmmap_pkg::REGION_OAM;
            res.target = TW'(a[7:0]);
            res.strobe = cmd;
        end else if (a < hmmap_pkg::ADDR_IO) begin
            res.region = hmmap_pkg::REGION_NONE;
        end else if (a == hmmap_pkg::ADDR_IE) begin
            res.region = hmmap_pkg::REGION_INT_REG;
            res.target = TW'(8'hFF);
            if (cmd == hmmap_pkg::CMD_WRITE) ie_q = d;
            else res.rval = ie_q;
        end else if (a > hmmap_pkg::ADDR_IO_END) begin
            res.region = hmmap_pkg::REGION_HIGH_RAM;
            res.target = TW'(a[6:0]);
            res.strobe = cmd;
        end else if (a == hmmap_pkg::ADDR_IO) begin
            res.region = hmmap_pkg::REGION_JOYPAD;
            res.strobe = cmd;
        end else if (a == hmmap_pkg::ADDR_IF) begin
            res.region = hmmap_pkg::REGION_INT_REG;
            res.target = TW'(8'h0F);
            if (cmd == hmmap_pkg::CMD_WRITE) if_q = d;
            else res.rval = if_q;
        end else if (a >= hmmap_pkg::ADDR_VIDEO) begin
            res.region = hmmap_pkg::REGION_VIDEO_REG;
            res.target = TW'(a - hmmap_pkg::ADDR_VIDEO);
            res.strobe = cmd;
        end
        res.ram_en = ram_en_q;
    endtask

    task automatic report_field(input string name, input int unsigned exp_val,
                                input int unsigned act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_access res;
        t_access exp_res;
        if (!i_rst_n) begin
            cart_type_q   = '0;
            boot_on       = 1'b1;
            rom_bank_q    = '0;
            window_bank_q = 7'd1;
            ram_bank_q    = '0;
            ram_en_q      = 1'b0;
            bank_mode_q   = 1'b0;
            ie_q          = '0;
            if_q          = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) cart_type_q = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with no transaction pending, %s %0d",
                             $time, "expected none, got region", i_region);
                    mismatches++;
                end else begin
                    exp_res = expected_q.pop_front();
                    report_field("region", exp_res.region, i_region);
                    report_field("target_addr", exp_res.target, i_target_addr);
                    report_field("write_strobe", exp_res.strobe, i_write_strobe);
                    report_field("read_value", exp_res.rval, i_read_value);
                    report_field("ram_enabled", exp_res.ram_en, i_ram_enabled);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_access(i_cmd, i_bus_addr, i_wr_data, i_pc_at_entry, res);
                expected_q.insert(expected_q.size(), res);
            end
        end
        pending = expected_q.size();
    end

endmodule

// ===== sim/handheld_memory_map_with_mbc1_unit_tb.sv =====
// Testbench top for the memory map / MBC1 unit: clock, reset, stimulus and verdict.
module handheld_memory_map_with_mbc1_unit_tb;

    localparam int unsigned ROM_BANK_BITS = 7;
    localparam int unsigned RAM_BANKS     = 4;
    localparam int          CYCLE_LIMIT   = 50000;
    localparam int          HOLD_CYCLES   = 60;

    logic                                i_clk         = 1'b0;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_valid   = 1'b0;
    logic [hmmap_pkg::DATA_W-1:0]        i_cfg_data    = '0;
    logic                                i_in_valid    = 1'b0;
    logic                                i_cmd         = 1'b0;
    logic [hmmap_pkg::ADDR_W-1:0]        i_bus_addr    = '0;
    logic [hmmap_pkg::DATA_W-1:0]        i_wr_data     = '0;
    logic                                i_pc_at_entry = 1'b0;
    logic                                i_out_stall   = 1'b0;

    logic                                o_cfg_ready;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic [3:0]                          o_region;
    logic [hmmap_pkg::TARGET_W-1:0]      o_target_addr;
    logic                                o_write_strobe;
    logic [hmmap_pkg::DATA_W-1:0]        o_read_value;
    logic                                o_ram_enabled;

    int fail_cnt;
    int pending;
    int cycle_cnt   = 0;
    int sent_cnt    = 0;
    int hold_asked  = 0;
    int hold_served = 0;
    int hold_left   = 0;
    bit no_idle     = 1'b0;

    handheld_memory_map_with_mbc1_unit #(
        .ROM_BANK_BITS(ROM_BANK_BITS),
        .RAM_BANKS    (RAM_BANKS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_bus_addr    (i_bus_addr),
        .i_wr_data     (i_wr_data),
        .i_pc_at_entry (i_pc_at_entry),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_region      (o_region),
        .o_target_addr (o_target_addr),
        .o_write_strobe(o_write_strobe),
        .o_read_value  (o_read_value),
        .o_ram_enabled (o_ram_enabled)
    );

    handheld_memory_map_with_mbc1_unit_checker #(
        .ROM_BANK_BITS(ROM_BANK_BITS),
        .RAM_BANKS    (RAM_BANKS)
    ) access_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_bus_addr    (i_bus_addr),
        .i_wr_data     (i_wr_data),
        .i_pc_at_entry (i_pc_at_entry),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_region      (o_region),
        .i_target_addr (o_target_addr),
        .i_write_strobe(o_write_strobe),
        .i_read_value  (o_read_value),
        .i_ram_enabled (o_ram_enabled),
        .o_fail_cnt    (fail_cnt),
        .o_pending     (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(99) < 8);
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("** handheld_memory_map_with_mbc1_unit: FAILED **");
        $finish;
    end

    task automatic send_access(input logic cmd, input logic [hmmap_pkg::ADDR_W-1:0] addr,
                               input logic [hmmap_pkg::DATA_W-1:0] data, input logic pc);
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_bus_addr    <= addr;
        i_wr_data     <= data;
        i_pc_at_entry <= pc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!no_idle && $urandom_range(99) < 8) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_cart_type(input logic [hmmap_pkg::DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // keep_boot holds pc_at_entry low on entry-range reads so the overlay survives
    task automatic run_phase(input logic [hmmap_pkg::DATA_W-1:0] cart, input int count,
                             input bit keep_boot, input bit with_hold);
        int                           kind;
        logic                         cmd;
        logic [hmmap_pkg::ADDR_W-1:0] addr;
        logic [hmmap_pkg::DATA_W-1:0] data;
        logic                         pc;
        wait_drained();
        write_cart_type(cart);
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            cmd  = 1'($urandom_range(1));
            addr = 16'($urandom_range(16'hFFFF));
            data = 8'($urandom_range(8'hFF));
            pc   = 1'($urandom_range(1));
            if (kind < 35) begin
                // bank controller programming
                cmd      = hmmap_pkg::CMD_WRITE;
                addr[15] = 1'b0;
                if (addr[14:13] == hmmap_pkg::MBC_RAM_EN && $urandom_range(1))
                    data[3:0] = hmmap_pkg::RAM_EN_KEY;
                if (addr[14:13] == hmmap_pkg::MBC_ROM_LOW && $urandom_range(3) == 0)
                    data[4:0] = 5'd0;
            end else if (kind < 55) begin
                cmd      = hmmap_pkg::CMD_READ;
                addr[15] = 1'b0;
                if ($urandom_range(3) == 0) addr[15:8] = 8'h00;
            end else if (kind < 70) begin
                addr[15:13] = 3'b101;
            end else if (kind < 85) begin
                addr[15:8] = 8'hFF;
                if ($urandom_range(3) == 0)
                    addr = $urandom_range(1) ? hmmap_pkg::ADDR_IE : hmmap_pkg::ADDR_IF;
            end
            if (keep_boot && cmd == hmmap_pkg::CMD_READ && addr >= hmmap_pkg::ADDR_BOOT_END
                && addr < hmmap_pkg::ADDR_ENTRY_END)
                pc = 1'b0;
            no_idle = (sent_cnt >= 200 && sent_cnt < 290);
            if (with_hold && i == count / 2) hold_asked++;
            send_access(cmd, addr, data, pc);
            sent_cnt++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // cartridge type 0 after reset: control writes leave the banks alone
        send_access(hmmap_pkg::CMD_READ,  16'h0000, 8'h00, 1'b1);  // below 0x0100, overlay stays
        send_access(hmmap_pkg::CMD_READ,  16'h00FF, 8'h00, 1'b0);
        send_access(hmmap_pkg::CMD_READ,  16'h0100, 8'h00, 1'b0);  // no entry flag, overlay stays
        send_access(hmmap_pkg::CMD_READ,  16'h1000, 8'h00, 1'b1);  // past the entry range
        send_access(hmmap_pkg::CMD_WRITE, 16'h2000, 8'h05, 1'b0);
        send_access(hmmap_pkg::CMD_READ,  16'h7FFF, 8'h00, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'h8000, 8'hFF, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'hBFFF, 8'h00, 1'b0);
        send_access(hmmap_pkg::CMD_READ,  16'hE000, 8'h00, 1'b0);  // echo of work RAM
        send_access(hmmap_pkg::CMD_READ,  16'hFE9F, 8'h00, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'hFEA0, 8'h11, 1'b0);
        send_access(hmmap_pkg::CMD_READ,  16'hFF04, 8'h00, 1'b0);  // timer reads as unmapped
        send_access(hmmap_pkg::CMD_WRITE, 16'hFF0F, 8'hFF, 1'b0);
        send_access(hmmap_pkg::CMD_READ,  16'hFF0F, 8'h00, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'hFFFF, 8'hA5, 1'b0);
        send_access(hmmap_pkg::CMD_READ,  16'hFFFF, 8'h00, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'hFF00, 8'h30, 1'b0);
        send_access(hmmap_pkg::CMD_READ,  16'hFF40, 8'h00, 1'b0);
        send_access(hmmap_pkg::CMD_READ,  16'hFF80, 8'h00, 1'b0);

        wait_drained();
        write_cart_type(hmmap_pkg::CART_MBC1);
        send_access(hmmap_pkg::CMD_WRITE, 16'h0000, 8'h0A, 1'b0);  // RAM enable
        send_access(hmmap_pkg::CMD_WRITE, 16'h2000, 8'h00, 1'b0);  // bank 0 becomes 1
        send_access(hmmap_pkg::CMD_WRITE, 16'h4000, 8'h03, 1'b0);  // upper bank bits
        send_access(hmmap_pkg::CMD_READ,  16'h4000, 8'h00, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'h6000, 8'h01, 1'b0);  // RAM banking mode
        send_access(hmmap_pkg::CMD_WRITE, 16'h5FFF, 8'h02, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'hA000, 8'h5A, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'h3FFF, 8'h1F, 1'b0);
        send_access(hmmap_pkg::CMD_WRITE, 16'h1FFF, 8'hF0, 1'b0);  // RAM disable

        run_phase(hmmap_pkg::CART_MBC1, 150, 1'b1, 1'b1);

        wait_drained();
        send_access(hmmap_pkg::CMD_READ, 16'h0100, 8'h00, 1'b1);   // entry read ends the overlay
        send_access(hmmap_pkg::CMD_READ, 16'h0000, 8'h00, 1'b0);

        run_phase(8'hFF, 100, 1'b0, 1'b0);
        run_phase(8'h00, 80, 1'b0, 1'b0);
        run_phase(hmmap_pkg::CART_MBC1, 150, 1'b0, 1'b1);
        run_phase(8'($urandom_range(2, 254)), 70, 1'b0, 1'b0);

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("** handheld_memory_map_with_mbc1_unit: PASSED **");
        end else begin
            $display("** handheld_memory_map_with_mbc1_unit: FAILED **");
        end
        $finish;
    end

endmodule
